// File: sv/dfm_pkg.sv
// ----------------------------------------------------------------------------
// dfm_pkg
// Shared types, widths and the twiddle table of the DFT magnitude block.
// ----------------------------------------------------------------------------
package dfm_pkg;

  localparam int POINTS       = 64;
  localparam int SAMPLE_BITS  = 16;
  localparam int TWIDDLE_BITS = 16;

  localparam int IDX_W   = $clog2(POINTS);
  localparam int ADDR_W  = IDX_W + 1;
  localparam int BANKS   = 2;
  localparam int PROD_W  = SAMPLE_BITS + TWIDDLE_BITS;
  localparam int ACC_W   = PROD_W + IDX_W;
  localparam int SUM_W   = ACC_W - (TWIDDLE_BITS - 1);
  localparam int RAD_W   = 2 * SUM_W;
  localparam int ROOT_W  = SUM_W;
  localparam int REM_W   = ROOT_W + 2;
  localparam int MAG_W   = 22;
  localparam int STEP_W  = $clog2(ROOT_W);
  localparam int QCNT_W  = 2;

  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

  typedef logic signed [SAMPLE_BITS-1:0]  sample_t;
  typedef logic signed [TWIDDLE_BITS-1:0] twid_t;
  typedef logic signed [PROD_W-1:0]       prod_t;
  typedef logic signed [ACC_W-1:0]        acc_t;
  typedef logic signed [SUM_W-1:0]        sum_t;
  typedef logic [IDX_W-1:0]               idx_t;
  typedef logic [MAG_W-1:0]               mag_t;

  typedef struct packed {
    sum_t re;
    sum_t im;
    idx_t bin;
    logic last;
  } bin_sum_t;

  typedef enum logic {
    MAC_IDLE,
    MAC_RUN
  } mac_state_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_SQUARE,
    SQ_ADD,
    SQ_ITER,
    SQ_HOLD
  } sqrt_state_t;

  // round(32767 * cos(2*pi*r/64)) for r = 0..16
  function automatic twid_t quarter_cos(logic [4:0] r);
    twid_t v;
    unique case (r)
      5'd0:    v = 16'sd32767;
      5'd1:    v = 16'sd32609;
      5'd2:    v = 16'sd32137;
      5'd3:    v = 16'sd31356;
      5'd4:    v = 16'sd30273;
      5'd5:    v = 16'sd28898;
      5'd6:    v = 16'sd27245;
      5'd7:    v = 16'sd25329;
      5'd8:    v = 16'sd23170;
      5'd9:    v = 16'sd20787;
      5'd10:   v = 16'sd18204;
      5'd11:   v = 16'sd15446;
      5'd12:   v = 16'sd12539;
      5'd13:   v = 16'sd9512;
      5'd14:   v = 16'sd6393;
      5'd15:   v = 16'sd3212;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

  function automatic twid_t tw_cos(idx_t a);
    logic [3:0] r;
    logic [4:0] rm;
    twid_t      v;
    r  = a[3:0];
    rm = 5'd16 - {1'b0, r};
    unique case (a[5:4])
      2'd0:    v = quarter_cos({1'b0, r});
      2'd1:    v = -quarter_cos(rm);
      2'd2:    v = -quarter_cos({1'b0, r});
      default: v = quarter_cos(rm);
    endcase
    return v;
  endfunction

  function automatic twid_t tw_sin(idx_t a);
    return tw_cos(a - idx_t'(POINTS / 4));
  endfunction

endpackage

// File: sv/dfm_if.sv
// ----------------------------------------------------------------------------
// dfm_if
// Sample and magnitude stream interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
interface dfm_in_if
  import dfm_pkg::*;
();
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface dfm_out_if
  import dfm_pkg::*;
();
  logic valid;
  logic ready;
  idx_t bin_index;
  mag_t magnitude;
  logic last_bin;

  modport source (output valid, output bin_index, output magnitude, output last_bin,
                  input ready);
  modport sink   (input valid, input bin_index, input magnitude, input last_bin,
                  output ready);
endinterface

// File: sv/dfm_ram.sv
// ----------------------------------------------------------------------------
// dfm_ram
// Generic one-write one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dfm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// File: sv/dfm_queue.sv
// ----------------------------------------------------------------------------
// dfm_queue
// Two-entry queue of completed-frame tokens (bank number).
// ----------------------------------------------------------------------------
module dfm_queue
  import dfm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic              push_bank,
  input  logic              pop,
  output logic              tok_valid,
  output logic              tok_bank,
  output logic [QCNT_W-1:0] count
);
  logic              ent_r [BANKS];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_pop;

  assign do_pop    = pop && (cnt_r != '0);
  assign tok_valid = (cnt_r != '0);
  assign tok_bank  = ent_r[rd_ptr_r];
  assign count     = cnt_r;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_bank;
    end
  end
endmodule

// File: sv/dfm_front.sv
// ----------------------------------------------------------------------------
// dfm_front
// Takes samples into the current bank and queues the bank once the frame is full.
// ----------------------------------------------------------------------------
module dfm_front
  import dfm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  dfm_in_if.sink            in_ch,
  input  logic [QCNT_W-1:0] q_count,
  input  logic              mac_busy,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output sample_t           wr_data,
  output logic              push,
  output logic              push_bank
);
  idx_t              fill_r, fill_nxt;
  logic              bank_r, bank_nxt;
  logic [QCNT_W-1:0] banks_used;
  logic              xfer;

  // both banks held by the back end: no free bank to fill
  assign banks_used  = q_count + QCNT_W'(mac_busy);
  assign in_ch.ready = (banks_used < QCNT_W'(BANKS));
  assign xfer        = in_ch.valid && in_ch.ready;

  assign wr_en     = xfer;
  assign wr_addr   = {bank_r, fill_r};
  assign wr_data   = in_ch.sample;
  assign push      = xfer && (fill_r == idx_t'(POINTS - 1));
  assign push_bank = bank_r;

  always_comb begin
    fill_nxt = fill_r;
    bank_nxt = bank_r;
    if (xfer) begin
      fill_nxt = fill_r + idx_t'(1);
      if (push) begin
        bank_nxt = ~bank_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      bank_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      bank_r <= bank_nxt;
    end
  end
endmodule

// File: sv/dfm_mac.sv
// ----------------------------------------------------------------------------
// dfm_mac
// Complex MAC over one bank, bin by bin, one sample per cycle unless stalled.
// ----------------------------------------------------------------------------
module dfm_mac
  import dfm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              tok_valid,
  input  logic              tok_bank,
  output logic              tok_pop,
  output logic              busy,
  output logic [ADDR_W-1:0] rd_addr,
  input  sample_t           rd_data,
  output logic              pend_valid,
  output bin_sum_t          pend,
  input  logic              pend_ready
);
  mac_state_t state_r, state_nxt;
  logic       bank_r;
  idx_t       k_r, j_r, ang_r;
  logic       iss, pipe_busy, j_last;

  logic       v1_r, first1_r, last1_r, blast1_r;
  idx_t       ang1_r, bin1_r;
  logic       v2_r, first2_r, last2_r, blast2_r;
  idx_t       bin2_r;
  prod_t      p_re_r, p_im_r;
  acc_t       acc_re_r, acc_im_r, acc_re_nxt, acc_im_nxt;
  logic       pend_v_r;
  bin_sum_t   pend_r;

  assign j_last    = (j_r == idx_t'(POINTS - 1));
  assign pipe_busy = v1_r || v2_r;
  // a bin starts only with an empty pipe and a free hand-off register
  assign iss = (state_r == MAC_RUN) && !((j_r == '0) && (pend_v_r || pipe_busy));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      MAC_IDLE: if (tok_valid) state_nxt = MAC_RUN;
      MAC_RUN:  if (iss && j_last && (k_r == idx_t'(POINTS - 1))) state_nxt = MAC_IDLE;
      default:  state_nxt = MAC_IDLE;
    endcase
  end

  always_comb begin
    tok_pop = 1'b0;
    busy    = 1'b0;
    unique case (state_r)
      MAC_IDLE: tok_pop = tok_valid;
      MAC_RUN:  busy    = 1'b1;
      default:  busy    = 1'b0;
    endcase
  end

  assign rd_addr = {bank_r, j_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MAC_IDLE;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= iss;
      v2_r    <= v1_r;
      if (v2_r && last2_r) begin
        pend_v_r <= 1'b1;
      end else if (pend_ready) begin
        pend_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r <= 1'b0;
      k_r    <= '0;
      j_r    <= '0;
      ang_r  <= '0;
    end else if (state_r == MAC_IDLE) begin
      if (tok_valid) begin
        bank_r <= tok_bank;
      end
      k_r   <= '0;
      j_r   <= '0;
      ang_r <= '0;
    end else if (iss) begin
      j_r <= j_r + idx_t'(1);
      if (j_last) begin
        ang_r <= '0;
        k_r   <= k_r + idx_t'(1);
      end else begin
        ang_r <= ang_r + k_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    ang1_r   <= ang_r;
    first1_r <= (j_r == '0);
    last1_r  <= j_last;
    bin1_r   <= k_r;
    blast1_r <= (k_r == idx_t'(POINTS - 1));

    p_re_r   <= prod_t'(rd_data * tw_cos(ang1_r));
    p_im_r   <= prod_t'(rd_data * tw_sin(ang1_r));
    first2_r <= first1_r;
    last2_r  <= last1_r;
    bin2_r   <= bin1_r;
    blast2_r <= blast1_r;
  end

  always_comb begin
    acc_re_nxt = (first2_r ? acc_t'(0) : acc_re_r) + acc_t'(p_re_r);
    acc_im_nxt = (first2_r ? acc_t'(0) : acc_im_r) - acc_t'(p_im_r);
  end

  always_ff @(posedge clk) begin
    if (v2_r) begin
      acc_re_r <= acc_re_nxt;
      acc_im_r <= acc_im_nxt;
      if (last2_r) begin
        pend_r.re   <= acc_re_nxt[ACC_W-1:TWIDDLE_BITS-1];
        pend_r.im   <= acc_im_nxt[ACC_W-1:TWIDDLE_BITS-1];
        pend_r.bin  <= bin2_r;
        pend_r.last <= blast2_r;
      end
    end
  end

  assign pend_valid = pend_v_r;
  assign pend       = pend_r;
endmodule

// File: sv/dfm_sqrt.sv
// ----------------------------------------------------------------------------
// dfm_sqrt
// Squares, sums and takes the floor square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module dfm_sqrt
  import dfm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      pend_valid,
  input  bin_sum_t  pend,
  output logic      pend_ready,
  dfm_out_if.source out_ch
);
  sqrt_state_t             state_r, state_nxt;
  logic [SUM_W-1:0]        a_r, b_r;
  logic [RAD_W-1:0]        sa_r, sb_r, rad_r;
  logic [ROOT_W-1:0]       root_r;
  logic [REM_W-1:0]        rem_r;
  logic [STEP_W-1:0]       step_r;
  idx_t                    bin_r;
  logic                    last_r;
  logic [REM_W+1:0]        rem_sh, trial;
  logic                    fits;

  assign rem_sh = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial  = (REM_W + 2)'({root_r, 2'b01});
  assign fits   = (rem_sh >= trial);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SQ_IDLE:   if (pend_valid) state_nxt = SQ_SQUARE;
      SQ_SQUARE: state_nxt = SQ_ADD;
      SQ_ADD:    state_nxt = SQ_ITER;
      SQ_ITER:   if (step_r == STEP_W'(ROOT_W - 1)) state_nxt = SQ_HOLD;
      SQ_HOLD:   if (out_ch.ready) state_nxt = SQ_IDLE;
      default:   state_nxt = SQ_IDLE;
    endcase
  end

  always_comb begin
    pend_ready   = 1'b0;
    out_ch.valid = 1'b0;
    unique case (state_r)
      SQ_IDLE: pend_ready   = 1'b1;
      SQ_HOLD: out_ch.valid = 1'b1;
      default: pend_ready   = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      SQ_IDLE: begin
        a_r    <= pend.re[SUM_W-1] ? SUM_W'(-pend.re) : SUM_W'(pend.re);
        b_r    <= pend.im[SUM_W-1] ? SUM_W'(-pend.im) : SUM_W'(pend.im);
        bin_r  <= pend.bin;
        last_r <= pend.last;
      end
      SQ_SQUARE: begin
        sa_r <= a_r * a_r;
        sb_r <= b_r * b_r;
      end
      SQ_ADD: begin
        rad_r  <= sa_r + sb_r;
        root_r <= '0;
        rem_r  <= '0;
        step_r <= '0;
      end
      SQ_ITER: begin
        rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
        step_r <= step_r + STEP_W'(1);
        if (fits) begin
          rem_r  <= REM_W'(rem_sh - trial);
          root_r <= {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r  <= REM_W'(rem_sh);
          root_r <= {root_r[ROOT_W-2:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

  assign out_ch.bin_index = bin_r;
  assign out_ch.last_bin  = last_r;
  assign out_ch.magnitude = (root_r > ROOT_W'(MAG_MAX)) ? MAG_MAX : root_r[MAG_W-1:0];
endmodule

// File: sv/dft_magnitude_spectrum.sv
// ----------------------------------------------------------------------------
// dft_magnitude_spectrum
// Direct DFT of 64-sample frames; emits floor magnitude of each bin in order.
// ----------------------------------------------------------------------------
//  channel | dir | payload                               | handshake
//  in_ch   | in  | sample[15:0] signed                   | valid/ready
//  out_ch  | out | bin_index[5:0] magnitude[21:0] last_bin | valid/ready
//
//  Samples are taken one per cycle when ready, into one of two sample banks.
//  Each bin runs 64 taps through the single complex MAC, then a pipe drain and
//  a hand-off to the root unit, so the bins of a frame follow one another.
//  The root of each bin is taken in its own unit, overlapped with the next bin.
//  Input stalls only when both banks wait for or are in the MAC; results hold
//  in the output register while out_ch is stalled. Reset clears all control state.
// ----------------------------------------------------------------------------
module dft_magnitude_spectrum
  import dfm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  dfm_in_if.sink    in_ch,
  dfm_out_if.source out_ch
);
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  sample_t           wr_data;
  logic [SAMPLE_BITS-1:0] rd_raw;
  logic              push, push_bank, tok_valid, tok_bank, tok_pop, mac_busy;
  logic [QCNT_W-1:0] q_count;
  logic              pend_valid, pend_ready;
  bin_sum_t          pend;

  dfm_front u_front (
    .clk, .rst_n, .in_ch, .q_count, .mac_busy,
    .wr_en, .wr_addr, .wr_data, .push, .push_bank
  );

  dfm_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(BANKS * POINTS)) u_ram (
    .clk, .wr_en, .wr_addr, .wr_data(wr_data), .rd_addr, .rd_data(rd_raw)
  );

  dfm_queue u_queue (
    .clk, .rst_n, .push, .push_bank, .pop(tok_pop),
    .tok_valid, .tok_bank, .count(q_count)
  );

  dfm_mac u_mac (
    .clk, .rst_n, .tok_valid, .tok_bank, .tok_pop, .busy(mac_busy),
    .rd_addr, .rd_data(sample_t'(rd_raw)), .pend_valid, .pend, .pend_ready
  );

  dfm_sqrt u_sqrt (
    .clk, .rst_n, .pend_valid, .pend, .pend_ready, .out_ch
  );

`ifndef ASSERT_OFF
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (q_count < QCNT_W'(BANKS)))
    else $error("frame queue overflow");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (q_count == QCNT_W'(BANKS)) |-> !in_ch.ready)
    else $error("input open with both banks held");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.last_bin == (out_ch.bin_index == idx_t'(POINTS - 1))))
    else $error("last bin flag mismatch");

  a_bin_order: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_valid && pend_ready) |=> !pend_valid || $past(pend.bin) != pend.bin)
    else $error("bin handed off twice");
`endif
endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream test of the DFT magnitude block: frames of signed samples go in with
// bursty timing, and each bin magnitude is checked in order against a model
// that rebuilds the twiddle table and does the direct DFT and integer root.
// ----------------------------------------------------------------------------
module tb_top
  import dfm_pkg::*;
;

  localparam int NUM_ITEMS  = 480;
  localparam int CYCLE_LIM  = 600000;
  localparam int DRAIN_CYC  = 400;
  localparam int HOLD_CYC   = 6000;

  class spectrum_scoreboard;
    int signed      cos_tab[POINTS];
    int signed      sin_tab[POINTS];
    longint signed  frame_buf[POINTS];
    int             fill;
    idx_t           exp_bin[$];
    mag_t           exp_mag[$];
    logic           exp_last[$];
    int             errors;

    function new();
      real ang;
      real c;
      real s;
      fill   = 0;
      errors = 0;
      for (int a = 0; a < POINTS; a++) begin
        ang = 2.0 * 3.14159265358979323846 * a / POINTS;
        c = 32767.0 * $cos(ang);
        s = 32767.0 * $sin(ang);
        cos_tab[a] = (c >= 0.0) ? $rtoi(c + 0.5) : -$rtoi(-c + 0.5);
        sin_tab[a] = (s >= 0.0) ? $rtoi(s + 0.5) : -$rtoi(-s + 0.5);
      end
    endfunction

    function longint unsigned int_root(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function int pending();
      return exp_mag.size();
    endfunction

    function void note_sample(sample_t s);
      longint signed re;
      longint signed im;
      longint unsigned ru;
      longint unsigned iu;
      longint unsigned m;
      frame_buf[fill] = longint'(s);
      fill++;
      if (fill < POINTS) return;
      fill = 0;
      for (int k = 0; k < POINTS; k++) begin
        re = 0;
        im = 0;
        for (int j = 0; j < POINTS; j++) begin
          re += frame_buf[j] * cos_tab[(j * k) % POINTS];
          im -= frame_buf[j] * sin_tab[(j * k) % POINTS];
        end
        re = re >>> (TWIDDLE_BITS - 1);
        im = im >>> (TWIDDLE_BITS - 1);
        ru = (re < 0) ? -re : re;
        iu = (im < 0) ? -im : im;
        m = int_root(ru * ru + iu * iu);
        if (m > 64'(MAG_MAX)) m = 64'(MAG_MAX);
        exp_bin  = {exp_bin, idx_t'(k)};
        exp_mag  = {exp_mag, mag_t'(m)};
        exp_last = {exp_last, logic'(k == POINTS - 1)};
      end
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_bin(idx_t bin, mag_t mag, logic last);
      if (exp_mag.size() == 0) begin
        report($sformatf("unexpected transfer bin %0d mag %0d", bin, mag));
        return;
      end
      if (bin !== exp_bin[0])
        report($sformatf("bin_index %0d, want %0d", bin, exp_bin[0]));
      if (mag !== exp_mag[0])
        report($sformatf("bin %0d magnitude %0d, want %0d", exp_bin[0], mag, exp_mag[0]));
      if (last !== exp_last[0])
        report($sformatf("bin %0d last_bin %b, want %b", exp_bin[0], last, exp_last[0]));
      void'(exp_bin.pop_front());
      void'(exp_mag.pop_front());
      void'(exp_last.pop_front());
    endtask
  endclass

  logic clk;
  logic rst_n;
  int   cycle = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  int   stall_mode = 0;

  dfm_in_if  in_ch ();
  dfm_out_if out_ch ();

  spectrum_scoreboard sb = new();

  dft_magnitude_spectrum dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.sink)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > CYCLE_LIM) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random stall pattern plus one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!hold_done && sb.pending() >= POINTS) begin
      hold_done    <= 1'b1;
      hold_left    <= HOLD_CYC;
      out_ch.ready <= 1'b0;
    end else begin
      if (cycle % 256 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
        2:       out_ch.ready <= ($urandom_range(0, 1) != 0);
        default: out_ch.ready <= (cycle % 5 != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_bin(out_ch.bin_index, out_ch.magnitude, out_ch.last_bin);
  end

  task send_sample(sample_t s);
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_sample(s);
    @(negedge clk);
  endtask

  function sample_t pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return sample_t'($urandom_range(0, 15)) - 16'sd8;
      default: return sample_t'($urandom());
    endcase
  endfunction

  sample_t directed[25] = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001,
                            16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh5555,
                            16'shAAAA, 16'sh00FF, 16'shFF00, 16'sh0F0F, 16'shF0F0,
                            16'sh4000, 16'shC000, 16'sh0100, 16'sh7FFE, 16'sh8001,
                            16'sh1234, 16'shEDCC, 16'sh0000, 16'sh0000, 16'sh7FFF};

  initial begin
    int sent;
    int burst;
    int gap;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) send_sample(directed[i]);
    sent = $size(directed);
    while (sent < NUM_ITEMS) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && sent < NUM_ITEMS; i++) begin
        send_sample(pick_sample());
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_ch.valid <= 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (sb.errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// File: dft_magnitude_spectrum.f
sv/dfm_pkg.sv
sv/dfm_if.sv
sv/dfm_ram.sv
sv/dfm_queue.sv
sv/dfm_front.sv
sv/dfm_mac.sv
sv/dfm_sqrt.sv
sv/dft_magnitude_spectrum.sv
tb/sv/tb_top.sv
